FILE: rtl/mdc_pkg.sv
// shared constants, types and the sine table function of the chorus core
package mdc_pkg;

    localparam int DELAY_DEPTH_DEF = 4096;
    localparam int SINE_DEPTH_DEF  = 1024;

    localparam int SAMPLE_W     = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MIX_AMOUNT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LFO_PHASE_STEP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOD_DEPTH      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_DELAY     = 2'd3;

    localparam logic [15:0] MIX_RESET        = 16'd0;
    localparam logic [31:0] PHASE_STEP_RESET = 32'd0;
    localparam logic [19:0] DEPTH_RESET      = 20'd0;
    localparam logic [11:0] BASE_RESET       = 12'd40;

    localparam logic [15:0] BYPASS_LIMIT = 16'd65;

    localparam longint SIN_C1 = 64'sd1686629713;
    localparam longint SIN_C3 = 64'sd693598668;
    localparam longint SIN_C5 = 64'sd85569306;
    localparam longint SIN_C7 = 64'sd5026992;
    localparam longint SIN_C9 = 64'sd172272;

    typedef struct packed {
        logic [15:0] mix_amount;
        logic [31:0] lfo_phase_step;
        logic [19:0] mod_depth;
        logic [11:0] base_delay;
    } cfg_t;

    // odd polynomial of the quarter sine, x in Q30, result in unsigned Q0.15
    function automatic logic [14:0] quarter_sine(input longint x);
        longint x2;
        longint p;
        longint r;
        x2 = (x * x) >>> 30;
        p  = SIN_C9;
        p  = SIN_C7 - ((x2 * p) >>> 30);
        p  = SIN_C5 - ((x2 * p) >>> 30);
        p  = SIN_C3 - ((x2 * p) >>> 30);
        p  = SIN_C1 - ((x2 * p) >>> 30);
        r  = (x * p) >>> 30;
        r  = (r + (64'sd1 <<< 14)) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        if (r < 64'sd0) begin
            r = 64'sd0;
        end
        return r[14:0];
    endfunction

endpackage

FILE: rtl/modulated_delay_chorus_core.sv
// top level of the modulated delay chorus core
// Mono chorus on signed 24-bit samples: a sine LFO modulates a fractional delay
// around base_delay, the delay ring is read at two neighbouring taps, linearly
// interpolated and mixed with the dry sample by mix_amount, rounded and
// saturated. A mixed item is taken in S_IDLE and walks the sequencer states
// S_ROM, S_MOD, S_POS, S_QUO, S_REM, S_RDA, S_RDB, S_WR, S_SUM and S_WET
// through the multiply chain and the ring wrap, sharing the single read port
// of the delay memory between both taps in S_RDA and S_RDB; S_OUT then loads
// the output register once it is free and returns to S_IDLE for the next item.
// With mix_amount at 65 or below an item passes straight through: S_IDLE goes
// to S_OUT, which loads the output register once it is free. The next item is
// taken while a result still waits on the output. After reset the delay memory
// is cleared one entry per cycle, all DELAY_DEPTH entries (4096 by default);
// s_ready stays low meanwhile, configuration writes are taken at all times.
module modulated_delay_chorus_core #(
    parameter int DELAY_DEPTH      = mdc_pkg::DELAY_DEPTH_DEF,
    parameter int SINE_TABLE_DEPTH = mdc_pkg::SINE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [mdc_pkg::SAMPLE_W-1:0] s_sample_in,
    input  logic                               s_last_in_block,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [mdc_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic                               m_last_out,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mdc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW     = $clog2(DELAY_DEPTH);
    localparam int TW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int K_WRAP = (8192 + DELAY_DEPTH - 1) / DELAY_DEPTH;
    localparam int OFS    = K_WRAP * DELAY_DEPTH;
    localparam int UMAX   = DELAY_DEPTH + 4096 + OFS;
    localparam int UW     = $clog2(UMAX + 1);
    localparam int VW     = UW + 1;
    localparam int SH     = UW;
    localparam longint RECIP = (longint'(1) << SH) / DELAY_DEPTH;
    localparam int RW     = $clog2(RECIP + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROM  = 4'd1;
    localparam logic [3:0] S_MOD  = 4'd2;
    localparam logic [3:0] S_POS  = 4'd3;
    localparam logic [3:0] S_QUO  = 4'd4;
    localparam logic [3:0] S_REM  = 4'd5;
    localparam logic [3:0] S_RDA  = 4'd6;
    localparam logic [3:0] S_RDB  = 4'd7;
    localparam logic [3:0] S_WR   = 4'd8;
    localparam logic [3:0] S_SUM  = 4'd9;
    localparam logic [3:0] S_WET  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    localparam logic signed [51:0] ROUND_HALF = 52'sd8388608;
    localparam logic signed [27:0] SAT_HI     = 28'sd8388607;
    localparam logic signed [27:0] SAT_LO     = -28'sd8388608;

    mdc_pkg::cfg_t cfg;

    logic [3:0]             state_reg;
    logic                   clearing_reg;
    logic [AW-1:0]          clr_cnt_reg;
    logic [AW-1:0]          wp_reg;
    logic [31:0]            phase_reg;
    logic                   m_valid_reg;

    logic signed [23:0]     x_reg;
    logic                   last_reg;
    logic                   bypass_reg;
    logic signed [36:0]     prod_reg;
    logic [UW-1:0]          u_reg;
    logic [7:0]             f_reg;
    logic [UW+RW-1:0]       qp_reg;
    logic [AW:0]            r_reg;
    logic [AW-1:0]          addr1_reg;
    logic signed [23:0]     a_reg;
    logic signed [32:0]     wa_reg;
    logic signed [32:0]     wb_reg;
    logic signed [40:0]     dry_reg;
    logic signed [33:0]     delayed_reg;
    logic signed [50:0]     wet_reg;
    logic signed [23:0]     out_sample_reg;
    logic                   out_last_reg;

    logic [29+TW:0]         tprod;
    logic [TW-1:0]          t_i;
    logic [TW-1:0]          tidx;
    logic [14:0]            rom_data;
    logic signed [15:0]     lfo_s;
    logic signed [20:0]     depth_s;
    logic signed [21:0]     mod_v;
    logic signed [22:0]     pos;
    logic signed [14:0]     d_s;
    logic signed [VW-1:0]   u_full;
    logic [RW-1:0]          q;
    logic [UW-1:0]          qd;
    logic [UW-1:0]          diff;
    logic [AW-1:0]          addr0;
    logic [AW-1:0]          addr1;
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [23:0]            ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [23:0]            ram_rd_data;
    logic signed [9:0]      w0_s;
    logic signed [9:0]      w1_s;
    logic signed [17:0]     dryc_s;
    logic signed [16:0]     mix_s;
    logic signed [51:0]     acc;
    logic signed [27:0]     y_full;
    logic signed [23:0]     y_sat;
    logic                   out_load;
    logic                   in_accept;

    mdc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mdc_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .TW               (TW)
    ) u_rom (
        .aclk    (aclk),
        .rd_idx  (tidx),
        .rd_data (rom_data)
    );

    mdc_delay_ram #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .AW          (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE) && !clearing_reg;
    assign in_accept = s_valid && s_ready;
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // lfo table index from the phase quadrant
    always_comb begin
        tprod = (30 + TW)'(phase_reg[29:0]) * (30 + TW)'(SINE_TABLE_DEPTH);
        t_i   = tprod[29+TW:30];
        tidx  = phase_reg[30] ? TW'(TW'(SINE_TABLE_DEPTH) - t_i) : t_i;
    end

    always_comb begin
        lfo_s   = phase_reg[31] ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
        depth_s = $signed({1'b0, cfg.mod_depth});
        mod_v   = 22'(prod_reg >>> 15);
        pos     = $signed({3'b000, cfg.base_delay, 8'h00}) + 23'(mod_v);
        d_s     = pos[22:8];
        u_full  = $signed(VW'(wp_reg)) + $signed(VW'(OFS)) - VW'(d_s);
        q       = qp_reg[UW+RW-1:SH];
        qd      = UW'(UW'(q) * UW'(DELAY_DEPTH));
        diff    = u_reg - qd;
        addr0   = (r_reg >= (AW + 1)'(DELAY_DEPTH)) ?
                  AW'(r_reg - (AW + 1)'(DELAY_DEPTH)) : r_reg[AW-1:0];
        addr1   = (addr0 == '0) ? AW'(DELAY_DEPTH - 1) : AW'(addr0 - AW'(1));
    end

    always_comb begin
        ram_wr_en   = clearing_reg || (state_reg == S_WR);
        ram_wr_addr = clearing_reg ? clr_cnt_reg : wp_reg;
        ram_wr_data = clearing_reg ? 24'd0 : x_reg;
        ram_rd_en   = (state_reg == S_RDA) || (state_reg == S_RDB);
        ram_rd_addr = (state_reg == S_RDA) ? addr0 : addr1_reg;
    end

    always_comb begin
        w0_s   = $signed({1'b0, 9'(9'd256 - {1'b0, f_reg})});
        w1_s   = $signed({2'b00, f_reg});
        dryc_s = $signed({1'b0, 17'(17'h10000 - {1'b0, cfg.mix_amount})});
        mix_s  = $signed({1'b0, cfg.mix_amount});
        acc    = (52'(dry_reg) <<< 8) + 52'(wet_reg) + ROUND_HALF;
        y_full = 28'(acc >>> 24);
        if (y_full > SAT_HI) begin
            y_sat = 24'sh7FFFFF;
        end else if (y_full < SAT_LO) begin
            y_sat = -24'sh800000;
        end else begin
            y_sat = y_full[23:0];
        end
    end

    // sequencer and control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            wp_reg       <= '0;
            phase_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (clearing_reg) begin
                clr_cnt_reg <= AW'(clr_cnt_reg + AW'(1));
                if (clr_cnt_reg == AW'(DELAY_DEPTH - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        state_reg <= (cfg.mix_amount <= mdc_pkg::BYPASS_LIMIT) ?
                                     S_OUT : S_ROM;
                    end
                end
                S_ROM: state_reg <= S_MOD;
                S_MOD: state_reg <= S_POS;
                S_POS: state_reg <= S_QUO;
                S_QUO: state_reg <= S_REM;
                S_REM: state_reg <= S_RDA;
                S_RDA: state_reg <= S_RDB;
                S_RDB: state_reg <= S_WR;
                S_WR: begin
                    wp_reg    <= (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : AW'(wp_reg + AW'(1));
                    phase_reg <= phase_reg + cfg.lfo_phase_step;
                    state_reg <= S_SUM;
                end
                S_SUM: state_reg <= S_WET;
                S_WET: state_reg <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            x_reg      <= s_sample_in;
            last_reg   <= s_last_in_block;
            bypass_reg <= (cfg.mix_amount <= mdc_pkg::BYPASS_LIMIT);
        end
        if (state_reg == S_MOD) begin
            prod_reg <= 37'(lfo_s) * 37'(depth_s);
        end
        if (state_reg == S_POS) begin
            u_reg <= u_full[UW-1:0];
            f_reg <= pos[7:0];
        end
        if (state_reg == S_QUO) begin
            qp_reg <= (UW + RW)'(u_reg) * (UW + RW)'(RECIP);
        end
        if (state_reg == S_REM) begin
            r_reg <= diff[AW:0];
        end
        if (state_reg == S_RDA) begin
            addr1_reg <= addr1;
        end
        if (state_reg == S_RDB) begin
            a_reg <= $signed(ram_rd_data);
        end
        if (state_reg == S_WR) begin
            wa_reg  <= 33'(a_reg) * 33'(w0_s);
            wb_reg  <= 33'($signed(ram_rd_data)) * 33'(w1_s);
            dry_reg <= 41'(x_reg) * 41'(dryc_s);
        end
        if (state_reg == S_SUM) begin
            delayed_reg <= 34'(wa_reg) + 34'(wb_reg);
        end
        if (state_reg == S_WET) begin
            wet_reg <= 51'(delayed_reg) * 51'(mix_s);
        end
        if (out_load) begin
            out_sample_reg <= bypass_reg ? x_reg : y_sat;
            out_last_reg   <= last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_sample_reg;
    assign m_last_out   = out_last_reg;

`ifndef SYNTHESIS
    a_no_item_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready)
        else $error("item accepted during ring clear");

    a_item_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("sequencer did not start on accepted item");

    a_result_from_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    a_state_moves_only_in_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_WR) |=> ($stable(wp_reg) && $stable(phase_reg)))
        else $error("write pointer or phase moved outside the write step");
`endif

endmodule

FILE: rtl/mdc_cfg_regs.sv
// configuration register bank of the chorus core
module mdc_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [mdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mdc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mdc_pkg::cfg_t                     cfg
);

    mdc_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mix_amount     <= mdc_pkg::MIX_RESET;
            cfg_reg.lfo_phase_step <= mdc_pkg::PHASE_STEP_RESET;
            cfg_reg.mod_depth      <= mdc_pkg::DEPTH_RESET;
            cfg_reg.base_delay     <= mdc_pkg::BASE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mdc_pkg::REG_MIX_AMOUNT: begin
                    cfg_reg.mix_amount <= cfg_data[15:0];
                end
                mdc_pkg::REG_LFO_PHASE_STEP: begin
                    cfg_reg.lfo_phase_step <= cfg_data[31:0];
                end
                mdc_pkg::REG_MOD_DEPTH: begin
                    cfg_reg.mod_depth <= cfg_data[19:0];
                end
                mdc_pkg::REG_BASE_DELAY: begin
                    cfg_reg.base_delay <= cfg_data[11:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/mdc_sine_rom.sv
// quarter-wave sine table with registered read
module mdc_sine_rom #(
    parameter int SINE_TABLE_DEPTH = mdc_pkg::SINE_DEPTH_DEF,
    parameter int TW               = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic          aclk,
    input  logic [TW-1:0] rd_idx,
    output logic [14:0]   rd_data
);

    logic [14:0] rom [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_entry
        localparam longint XK = (longint'(k) << 30) / SINE_TABLE_DEPTH;
        assign rom[k] = mdc_pkg::quarter_sine(XK);
    end

    always_ff @(posedge aclk) begin
        if (rd_idx > TW'(SINE_TABLE_DEPTH)) begin
            rd_data <= '0;
        end else begin
            rd_data <= rom[rd_idx];
        end
    end

endmodule

FILE: rtl/mdc_delay_ram.sv
// delay ring storage, one write and one registered read port
module mdc_delay_ram #(
    parameter int DELAY_DEPTH = mdc_pkg::DELAY_DEPTH_DEF,
    parameter int AW          = $clog2(DELAY_DEPTH)
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [AW-1:0]                wr_addr,
    input  logic [mdc_pkg::SAMPLE_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [AW-1:0]                rd_addr,
    output logic [mdc_pkg::SAMPLE_W-1:0] rd_data
);

    logic [mdc_pkg::SAMPLE_W-1:0] mem [0:DELAY_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
